// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the rtl file that carries checks, the top level
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/rcsa_pkg.sv -----
// shared constants, codes and control types of the cache slot allocator
// no dependencies; used by the top level, rcsa_ctl, rcsa_dp and the testbench
`default_nettype none

package rcsa_pkg;

  localparam int CACHE_SLOTS   = 16;
  localparam int NUM_RESOURCES = 256;

  localparam int SLOT_W  = $clog2(CACHE_SLOTS);
  localparam int RES_W   = $clog2(NUM_RESOURCES);
  localparam int CNT_W   = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int ID_W     = 8;
  localparam int RSLOT_W  = 4;
  localparam int OSLOT_W  = 4;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam int ID_EXT_W  = (RES_W > ID_W) ? RES_W : ID_W;
  localparam int REL_EXT_W = ((SLOT_W > RSLOT_W) ? SLOT_W : RSLOT_W) + 1;
  localparam int OUT_EXT_W = (SLOT_W > OSLOT_W) ? SLOT_W : OSLOT_W;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_IDLE_REL = 2'd2,
    ST_OVERFLOW = 2'd3
  } rcsa_status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOOK,
    OP_SRCH_INIT,
    OP_SRCH_STEP,
    OP_BIND_CUR,
    OP_BIND_FOUND,
    OP_INC,
    OP_DEC,
    OP_ERR_FULL,
    OP_ERR_OVF,
    OP_ERR_IDLE
  } rcsa_op_t;

  typedef struct packed {
    rcsa_op_t op;
    logic     out_load;
  } rcsa_cmd_t;

  typedef struct packed {
    logic res_hit;
    logic owned;
    logic cnt_zero;
    logic cnt_max;
    logic srch_last;
  } rcsa_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/refcounted_cache_slot_allocator_top.sv -----
// top level of the reference-counted cache slot allocator
// depends on rcsa_pkg, rcsa_ctl, rcsa_dp, rcsa_ram and assert_macros.svh
//
// usage: each request on the in_ stream is an acquire (in_tuser 0) of a slot
// for resource_id or a release (in_tuser 1) of release_slot. every request
// gives exactly one result on the out_ stream: slot, needs_load and status.
// one request is worked on at a time; in_tready is high only while idle.
// after a request is loaded, a release decrements the count of release_slot in
// S_REL, or reports an idle release if it is zero. an acquire reads the slot
// remembered for its id (S_LOOK) and its owner (S_OWN): it reuses that slot if
// the id still owns it or reclaims it if unused; with no remembered slot, or
// one now busy, it searches (S_SEARCH). the free-slot search tests one slot per
// cycle from the round-robin pointer; the next request is taken the cycle after
// the result is registered, even while that result still waits on out_tready.
// a stalled receiver holds the result; the block then waits before writing
// the next one. reset clears all bindings, counts and the search pointer at
// once; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module refcounted_cache_slot_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rcsa_pkg::IN_TDATA_W-1:0]     in_tdata,  // resource_id, release_slot
  input  logic                                in_tuser,  // cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rcsa_pkg::OUT_TDATA_W-1:0]    out_tdata  // slot, needs_load, status
);
  import rcsa_pkg::*;

  rcsa_cmd_t      cmd;
  rcsa_sts_t      sts;
  logic [OSLOT_W-1:0] out_slot;
  logic           out_needs_load;
  rcsa_status_t   out_status;

  rcsa_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rcsa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_tuser),
    .in_id          (in_tdata[ID_W-1:0]),
    .in_rel         (in_tdata[ID_W+RSLOT_W-1:ID_W]),
    .cmd            (cmd),
    .sts            (sts),
    .out_slot       (out_slot),
    .out_needs_load (out_needs_load),
    .out_status     (out_status)
  );

  assign out_tdata = {1'b0, out_status, out_needs_load, out_slot};

  // a result is never written over one still waiting
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.out_load, !out_tvalid || out_tready)
  // one request in flight at a time
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a newly bound slot is always a successful acquire
  `ASSERT_IMPLIES(a_load_is_ok, clk, rst_n, out_tvalid && out_needs_load, out_status == ST_OK)

endmodule

`default_nettype wire

// ----- rtl/core/rcsa_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used by the allocator datapath
`default_nettype none

module rcsa_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rcsa_dp.sv -----
// allocator datapath: id and owner tables, use counts, search pointer, result
// depends on rcsa_pkg and rcsa_ram; driven by rcsa_ctl commands
`default_nettype none

module rcsa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_cmd,
  input  logic [rcsa_pkg::ID_W-1:0]    in_id,
  input  logic [rcsa_pkg::RSLOT_W-1:0] in_rel,
  input  rcsa_pkg::rcsa_cmd_t          cmd,
  output rcsa_pkg::rcsa_sts_t          sts,
  output logic [rcsa_pkg::OSLOT_W-1:0] out_slot,
  output logic                         out_needs_load,
  output rcsa_pkg::rcsa_status_t       out_status
);
  import rcsa_pkg::*;

  logic [NUM_RESOURCES-1:0] rv_r, rv_nxt;
  logic [CACHE_SLOTS-1:0]   ov_r, ov_nxt;
  logic [CACHE_SLOTS-1:0]   zf_r, zf_nxt;
  logic [SLOT_W-1:0]        sp_r, sp_nxt;

  logic [RES_W-1:0]   id_r;
  logic [RSLOT_W-1:0] rel_r;
  logic               cmd_r;
  logic               rel_ok_r;
  logic               rvh_r;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  k_r, k_nxt;

  logic [ID_EXT_W-1:0]  id_ext;
  logic [RES_W-1:0]     id_idx;
  logic [REL_EXT_W-1:0] rel_ext;
  logic [SLOT_W-1:0]    rel_idx;
  logic                 rel_ok;
  logic [OUT_EXT_W-1:0] cur_ext;

  logic [SLOT_W-1:0] res_rd;
  logic [RES_W-1:0]  own_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  cnt_val;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [SLOT_W-1:0] cnt_raddr;
  logic              is_bind;
  logic              cnt_we;
  logic              cnt_re;

  assign id_ext  = ID_EXT_W'(in_id);
  assign id_idx  = id_ext[RES_W-1:0];
  assign rel_ext = REL_EXT_W'(in_rel);
  assign rel_ok  = rel_ext < REL_EXT_W'(CACHE_SLOTS);
  assign rel_idx = rel_ext[SLOT_W-1:0];
  assign cur_ext = OUT_EXT_W'(cur_r);

  assign is_bind   = (cmd.op == OP_BIND_CUR) || (cmd.op == OP_BIND_FOUND);
  assign cnt_we    = is_bind || (cmd.op == OP_INC) || (cmd.op == OP_DEC);
  assign cnt_re    = (cmd.op == OP_LOAD) || (cmd.op == OP_LOOK);
  assign cnt_raddr = (cmd.op == OP_LOAD) ? rel_idx : res_rd;
  assign cnt_val   = zf_r[cur_r] ? '0 : cnt_rd;

  always_comb begin
    case (cmd.op)
      OP_BIND_CUR, OP_BIND_FOUND: cnt_wdata = CNT_W'(1);
      OP_INC:                     cnt_wdata = cnt_val + CNT_W'(1);
      default:                    cnt_wdata = cnt_val - CNT_W'(1);
    endcase
  end

  // slot remembered for each id
  rcsa_ram #(.W(SLOT_W), .D(NUM_RESOURCES)) u_res_ram (
    .clk   (clk),
    .we    (is_bind),
    .waddr (id_r),
    .wdata (cur_r),
    .re    (cmd.op == OP_LOAD),
    .raddr (id_idx),
    .rdata (res_rd)
  );

  // owner id of each slot
  rcsa_ram #(.W(RES_W), .D(CACHE_SLOTS)) u_own_ram (
    .clk   (clk),
    .we    (is_bind),
    .waddr (cur_r),
    .wdata (id_r),
    .re    (cmd.op == OP_LOOK),
    .raddr (res_rd),
    .rdata (own_rd)
  );

  // use count of each slot, zero while its zero flag is set
  rcsa_ram #(.W(CNT_W), .D(CACHE_SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cur_r),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  always_comb begin
    rv_nxt = rv_r;
    ov_nxt = ov_r;
    zf_nxt = zf_r;
    sp_nxt = sp_r;
    if (is_bind) begin
      rv_nxt[id_r]  = 1'b1;
      ov_nxt[cur_r] = 1'b1;
      zf_nxt[cur_r] = 1'b0;
    end
    if (cmd.op == OP_INC) begin
      zf_nxt[cur_r] = 1'b0;
    end
    if (cmd.op == OP_DEC) begin
      zf_nxt[cur_r] = (cnt_val == CNT_W'(1));
    end
    if (cmd.op == OP_BIND_FOUND) begin
      sp_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
      ov_r <= '0;
      zf_r <= '1;
      sp_r <= '0;
    end else begin
      rv_r <= rv_nxt;
      ov_r <= ov_nxt;
      zf_r <= zf_nxt;
      sp_r <= sp_nxt;
    end
  end

  always_comb begin
    cur_nxt = cur_r;
    k_nxt   = k_r;
    case (cmd.op)
      OP_LOAD:      cur_nxt = rel_idx;
      OP_LOOK:      cur_nxt = res_rd;
      OP_SRCH_INIT: begin
        cur_nxt = sp_r;
        k_nxt   = '0;
      end
      OP_SRCH_STEP: begin
        cur_nxt = (cur_r == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : cur_r + SLOT_W'(1);
        k_nxt   = k_r + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    if (cmd.op == OP_LOAD) begin
      id_r     <= id_idx;
      rel_r    <= in_rel;
      cmd_r    <= in_cmd;
      rel_ok_r <= rel_ok;
      rvh_r    <= rv_r[id_idx];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_needs_load <= is_bind;
      if (cmd.op == OP_ERR_FULL) begin
        out_slot <= '0;
      end else if (cmd_r == CMD_RELEASE) begin
        out_slot <= rel_r;
      end else begin
        out_slot <= cur_ext[OSLOT_W-1:0];
      end
      case (cmd.op)
        OP_ERR_FULL: out_status <= ST_FULL;
        OP_ERR_IDLE: out_status <= ST_IDLE_REL;
        OP_ERR_OVF:  out_status <= ST_OVERFLOW;
        default:     out_status <= ST_OK;
      endcase
    end
  end

  assign sts.res_hit   = rvh_r;
  assign sts.owned     = ov_r[cur_r] && (own_rd == id_r);
  assign sts.cnt_zero  = zf_r[cur_r] || ((cmd_r == CMD_RELEASE) && !rel_ok_r);
  assign sts.cnt_max   = !zf_r[cur_r] && (cnt_rd == CNT_MAX);
  assign sts.srch_last = (k_r == SLOT_W'(CACHE_SLOTS - 1));

endmodule

`default_nettype wire

// ----- rtl/core/rcsa_ctl.sv -----
// allocator controller: request sequencing, slot search loop, result handshake
// depends on rcsa_pkg; steers rcsa_dp through command and status structs
`default_nettype none

module rcsa_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_cmd,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  rcsa_pkg::rcsa_sts_t sts,
  output rcsa_pkg::rcsa_cmd_t cmd
);
  import rcsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_LOOK,
    S_OWN,
    S_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_cmd == CMD_RELEASE) ? S_REL : S_LOOK;
        end
      end
      S_REL: begin
        if (out_free) begin
          cmd.op       = sts.cnt_zero ? OP_ERR_IDLE : OP_DEC;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LOOK: begin
        if (sts.res_hit) begin
          cmd.op    = OP_LOOK;
          state_nxt = S_OWN;
        end else begin
          cmd.op    = OP_SRCH_INIT;
          state_nxt = S_SEARCH;
        end
      end
      S_OWN: begin
        if (sts.owned || sts.cnt_zero) begin
          if (out_free) begin
            if (sts.owned) begin
              cmd.op = sts.cnt_max ? OP_ERR_OVF : OP_INC;
            end else begin
              cmd.op = OP_BIND_CUR;
            end
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.op    = OP_SRCH_INIT;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.cnt_zero || sts.srch_last) begin
          if (out_free) begin
            cmd.op       = sts.cnt_zero ? OP_BIND_FOUND : OP_ERR_FULL;
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.op = OP_SRCH_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/refcounted_cache_slot_allocator_top_tb.sv -----
// testbench for refcounted_cache_slot_allocator_top: directed and random acquire/release traffic
// checked against an in-bench slot allocator model; depends on rcsa_pkg and the rtl only
`timescale 1ns / 1ps

module refcounted_cache_slot_allocator_top_tb;
  import rcsa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 3 + CACHE_SLOTS + 8;

  typedef struct packed {
    logic [OSLOT_W-1:0] slot;
    logic               needs_load;
    rcsa_status_t       status;
  } slot_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // allocator state as the block should hold it
  logic                 id_bound    [NUM_RESOURCES];
  logic [SLOT_W-1:0]    id_slot     [NUM_RESOURCES];
  logic                 owner_valid [CACHE_SLOTS];
  logic [RES_W-1:0]     owner_id    [CACHE_SLOTS];
  logic [CNT_W-1:0]     slot_users  [CACHE_SLOTS];
  logic [SLOT_W-1:0]    rr_ptr;

  slot_result_t pending_results[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int acquires_sent;
  int releases_sent;
  int results_checked;
  int status_seen[4];
  int load_seen;
  longint cycle_count;

  refcounted_cache_slot_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic slot_result_t allocate_or_release(logic cmd, logic [ID_W-1:0] id,
                                                       logic [RSLOT_W-1:0] rs);
    slot_result_t     r;
    logic [SLOT_W-1:0] c;
    logic [SLOT_W-1:0] p;
    logic             found;
    int               k;
    r.slot       = '0;
    r.needs_load = 1'b0;
    r.status     = ST_OK;
    if (cmd == CMD_RELEASE) begin
      r.slot = rs;
      if (slot_users[rs] == '0) begin
        r.status = ST_IDLE_REL;
      end else begin
        slot_users[rs] = slot_users[rs] - 1'b1;
      end
      return r;
    end
    found = 1'b0;
    c     = '0;
    if (id_bound[id]) begin
      c = id_slot[id];
      if (owner_valid[c] && owner_id[c] == id) begin
        r.slot = c;
        if (slot_users[c] == CNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          slot_users[c] = slot_users[c] + 1'b1;
        end
        return r;
      end
      if (slot_users[c] == '0) found = 1'b1;
    end
    if (!found) begin
      // round-robin scan for an unused slot
      p = rr_ptr;
      for (k = 0; k < CACHE_SLOTS && !found; k++) begin
        if (slot_users[p] == '0) begin
          found = 1'b1;
        end else begin
          p = p + 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
        return r;
      end
      rr_ptr = p;
      c      = p;
    end
    owner_valid[c] = 1'b1;
    owner_id[c]    = id;
    id_bound[id]   = 1'b1;
    id_slot[id]    = c;
    slot_users[c]  = CNT_W'(1);
    r.slot       = c;
    r.needs_load = 1'b1;
    return r;
  endfunction

  task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                              input logic [RSLOT_W-1:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - ID_W - RSLOT_W){1'b0}}, rs, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(allocate_or_release(cmd, id, rs));
    if (cmd == CMD_RELEASE) releases_sent++;
    else acquires_sent++;
  endtask

  task automatic acquire(input logic [ID_W-1:0] id);
    send_request(CMD_ACQUIRE, id, RSLOT_W'($urandom_range(15)));
  endtask

  task automatic release_slot(input logic [RSLOT_W-1:0] rs);
    send_request(CMD_RELEASE, ID_W'($urandom_range(255)), rs);
  endtask

  // bring every use count back to zero
  task automatic release_all;
    int s;
    for (s = 0; s < CACHE_SLOTS; s++) begin
      while (slot_users[s] != '0) release_slot(RSLOT_W'(s));
    end
  endtask

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    $display("[%0t] mismatch on %s: expected %0d, got %0d (result %0d)",
             $realtime, what, expv, gotv, results_checked);
    mismatch_count++;
  endtask

  task automatic test_basic_requests;
    acquire(8'h00);
    acquire(8'h00);
    acquire(8'hFF);
    release_slot(id_slot[8'h00]);
    release_slot(id_slot[8'h00]);
    release_slot(id_slot[8'h00]);
    release_slot(4'hF);
    acquire(8'h00);
    release_slot(id_slot[8'h00]);
    acquire(8'hFF);
  endtask

  task automatic test_full_cache;
    int i;
    release_all();
    for (i = 0; i <= CACHE_SLOTS; i++) acquire(ID_W'(16 + i));
    acquire(8'd20);
    release_all();
  endtask

  // an id whose slot may have been taken over comes back, as does one that still holds its slot
  task automatic test_stale_binding;
    int i;
    for (i = 0; i < 4; i++) acquire(ID_W'(200 + i));
    release_slot(id_slot[200]);
    for (i = 16; i < 24; i++) acquire(ID_W'(i));
    acquire(8'd200);
    acquire(8'd201);
    release_all();
  endtask

  // one slot is driven to its count limit and left held just below it
  task automatic test_count_overflow;
    int i;
    release_all();
    for (i = 0; i <= int'(CNT_MAX); i++) acquire(8'hA5);
    release_slot(id_slot[8'hA5]);
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    int k;
    int roll;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] s;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 58) begin
        if ($urandom_range(9) == 0) id = ID_W'($urandom_range(255));
        else id = ID_W'($urandom_range(23));
        acquire(id);
      end else if (roll < 92) begin
        s = SLOT_W'($urandom_range(15));
        for (k = 0; k < CACHE_SLOTS && slot_users[s] == '0; k++) s = s + 1'b1;
        release_slot(s);
      end else begin
        release_slot(RSLOT_W'($urandom_range(15)));
      end
    end
  endtask

  task automatic wait_for_results;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    slot_result_t expv;
    slot_result_t gotv;
    if (rst_n && out_tvalid && out_tready) begin
      gotv.slot       = out_tdata[OSLOT_W-1:0];
      gotv.needs_load = out_tdata[OSLOT_W];
      gotv.status     = rcsa_status_t'(out_tdata[OSLOT_W+1 +: STATUS_W]);
      status_seen[gotv.status]++;
      if (gotv.needs_load) load_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", -1, int'(out_tdata));
      end else begin
        expv = pending_results.pop_front();
        if (gotv.slot != expv.slot)
          report_mismatch("slot", int'(expv.slot), int'(gotv.slot));
        if (gotv.needs_load != expv.needs_load)
          report_mismatch("needs_load", int'(expv.needs_load), int'(gotv.needs_load));
        if (gotv.status != expv.status)
          report_mismatch("status", int'(expv.status), int'(gotv.status));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_ACQUIRE;
    out_tready <= 1'b0;
    for (i = 0; i < NUM_RESOURCES; i++) begin
      id_bound[i] = 1'b0;
      id_slot[i]  = '0;
    end
    for (i = 0; i < CACHE_SLOTS; i++) begin
      owner_valid[i] = 1'b0;
      owner_id[i]    = '0;
      slot_users[i]  = '0;
    end
    rr_ptr = '0;
    send_idle_pct = 14;
    recv_idle_pct = 82;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_full_cache();
    test_stale_binding();
    test_random_traffic(20);

    send_idle_pct = 82;
    recv_idle_pct = 14;
    test_count_overflow();
    test_random_traffic(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(30);
    in_tvalid <= 1'b0;
    wait_for_results();

    $display("%0d acquires and %0d releases sent, %0d results checked, %0d needed a load",
             acquires_sent, releases_sent, results_checked, load_seen);
    $display("status ok %0d, cache full %0d, idle release %0d, count overflow %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_IDLE_REL],
             status_seen[ST_OVERFLOW]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
